// ===== design/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg: shared types and constants of the UTF-8 to codepage converter
// Word formats, kind codes, decode limits and the token that travels down
// the row of table cells.
// ----------------------------------------------------------------------------
package u2c_pkg;

  // Table geometry. Each cell holds CELL_ENTRIES consecutive slots.
  localparam int TABLE_ENTRIES = 128;
  localparam int SLOT_W        = 7;
  localparam int CELL_SEL_W    = 3;
  localparam int CELL_ENTRIES  = 1 << CELL_SEL_W;
  localparam int CELL_ID_W     = SLOT_W - CELL_SEL_W;
  localparam int NUM_CELLS     = (TABLE_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;

  localparam int CODE_W = 21;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Result kind codes.
  localparam logic [KIND_W-1:0] RES_CONV    = 2'd0;
  localparam logic [KIND_W-1:0] RES_INVALID = 2'd1;
  localparam logic [KIND_W-1:0] RES_SUMMARY = 2'd2;

  // Lead byte ranges and code point limits.
  localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hc2;
  localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hdf;
  localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hef;
  localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hf4;
  localparam logic [1:0]        CONT_TAG   = 2'b10;
  localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10ffff;
  localparam logic [CODE_W-1:0] SURR_LO    = 21'h00d800;
  localparam logic [CODE_W-1:0] SURR_HI    = 21'h00dfff;
  localparam logic [CODE_W-1:0] BOM_CODE   = 21'h00feff;
  localparam logic [CODE_W-1:0] LOST_MAX   = 21'd1048576;

  // Minimum class codes of a multi-byte sequence.
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [BYTE_W-1:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [CODE_W-1:0] lost_count;
    logic              failed;
  } out_word_t;

  typedef enum logic [1:0] {
    TOK_LOAD,
    TOK_LOOKUP,
    TOK_DIRECT
  } tok_op_t;

  // Token handed from cell to cell, one per accepted word that has an effect.
  typedef struct packed {
    logic              vld;
    tok_op_t           op;
    logic [KIND_W-1:0] rkind;
    logic [BYTE_W-1:0] byte_val;
    logic              failed;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic              hit;
  } token_t;

  // Smallest legal code point of a sequence of the given class.
  function automatic logic [CODE_W-1:0] min_code(input logic [1:0] cls);
    logic [CODE_W-1:0] m;
    case (cls)
      CLS_TWO:   m = 21'h000080;
      CLS_THREE: m = 21'h000800;
      default:   m = 21'h010000;
    endcase
    return m;
  endfunction

endpackage

// ===== design/u2c_decoder.sv =====
// ----------------------------------------------------------------------------
// u2c_decoder: UTF-8 validation and decode front end
// Checks and assembles code points, tracks the per-text state and issues
// one token per word that has an effect into the head of the cell row.
// ----------------------------------------------------------------------------
module u2c_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              item_valid,
  input  u2c_pkg::in_word_t item,
  output u2c_pkg::token_t   tok
);

  logic [u2c_pkg::CODE_W-1:0] partial, partial_next;
  logic [1:0]                 pending, pending_next;
  logic [1:0]                 cls, cls_next;
  logic                       any_output, any_output_next;
  logic                       error_seen, error_seen_next;
  u2c_pkg::token_t            tok_next;

  logic                       accept;
  logic [u2c_pkg::BYTE_W-1:0] b;
  logic [u2c_pkg::CODE_W-1:0] cp_join;
  logic                       emit_req;
  logic [u2c_pkg::CODE_W-1:0] emit_cp;
  logic                       err_req;

  assign accept  = item_valid && adv;
  assign b       = item.text_byte;
  assign cp_join = {partial[u2c_pkg::CODE_W-7:0], b[5:0]};

  // Decode of one accepted word.
  always_comb begin
    partial_next    = partial;
    pending_next    = pending;
    cls_next        = cls;
    any_output_next = any_output;
    error_seen_next = error_seen;
    tok_next        = '0;
    tok_next.op     = u2c_pkg::TOK_DIRECT;
    emit_req        = 1'b0;
    emit_cp         = '0;
    err_req         = 1'b0;

    if (accept) begin
      case (item.kind)
        u2c_pkg::KIND_LOAD: begin
          if ({1'b0, item.entry_index} < (u2c_pkg::SLOT_W + 1)'(u2c_pkg::TABLE_ENTRIES)) begin
            tok_next.vld  = 1'b1;
            tok_next.op   = u2c_pkg::TOK_LOAD;
            tok_next.slot = item.entry_index;
            tok_next.code = item.entry_code;
          end
        end
        u2c_pkg::KIND_TEXT: begin
          if (!error_seen) begin
            if (pending != 2'd0) begin
              if (b[7:6] != u2c_pkg::CONT_TAG) begin
                err_req = 1'b1;
              end else begin
                partial_next = cp_join;
                pending_next = pending - 2'd1;
                if (pending == 2'd1) begin
                  cls_next = u2c_pkg::CLS_NONE;
                  if (cp_join < u2c_pkg::min_code(cls) || cp_join > u2c_pkg::CODE_MAX ||
                      (cp_join >= u2c_pkg::SURR_LO && cp_join <= u2c_pkg::SURR_HI)) begin
                    err_req = 1'b1;
                  end else begin
                    emit_req = 1'b1;
                    emit_cp  = cp_join;
                  end
                end
              end
            end else if (b == '0) begin
              err_req = 1'b1;
            end else if (b < u2c_pkg::ASCII_END) begin
              emit_req = 1'b1;
              emit_cp  = u2c_pkg::CODE_W'(b);
            end else if (b inside {[u2c_pkg::LEAD2_LO:u2c_pkg::LEAD2_HI]}) begin
              partial_next = u2c_pkg::CODE_W'(b[4:0]);
              pending_next = 2'd1;
              cls_next     = u2c_pkg::CLS_TWO;
            end else if (b inside {[u2c_pkg::LEAD3_LO:u2c_pkg::LEAD3_HI]}) begin
              partial_next = u2c_pkg::CODE_W'(b[3:0]);
              pending_next = 2'd2;
              cls_next     = u2c_pkg::CLS_THREE;
            end else if (b inside {[u2c_pkg::LEAD4_LO:u2c_pkg::LEAD4_HI]}) begin
              partial_next = u2c_pkg::CODE_W'(b[2:0]);
              pending_next = 2'd3;
              cls_next     = u2c_pkg::CLS_FOUR;
            end else begin
              err_req = 1'b1;
            end
          end
        end
        u2c_pkg::KIND_END: begin
          tok_next.vld    = 1'b1;
          tok_next.op     = u2c_pkg::TOK_DIRECT;
          tok_next.rkind  = u2c_pkg::RES_SUMMARY;
          tok_next.failed = error_seen || (pending != 2'd0);
          partial_next    = '0;
          pending_next    = 2'd0;
          cls_next        = u2c_pkg::CLS_NONE;
          any_output_next = 1'b0;
          error_seen_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // An error drops the sequence and is reported once.
    if (err_req) begin
      error_seen_next = 1'b1;
      pending_next    = 2'd0;
      cls_next        = u2c_pkg::CLS_NONE;
      partial_next    = '0;
      tok_next.vld    = 1'b1;
      tok_next.op     = u2c_pkg::TOK_DIRECT;
      tok_next.rkind  = u2c_pkg::RES_INVALID;
      tok_next.failed = 1'b1;
    end

    // A finished code point; a BOM before any output is dropped.
    if (emit_req && !(emit_cp == u2c_pkg::BOM_CODE && !any_output)) begin
      any_output_next = 1'b1;
      tok_next.vld    = 1'b1;
      tok_next.rkind  = u2c_pkg::RES_CONV;
      if (emit_cp < u2c_pkg::CODE_W'(u2c_pkg::ASCII_END)) begin
        tok_next.op       = u2c_pkg::TOK_DIRECT;
        tok_next.byte_val = emit_cp[u2c_pkg::BYTE_W-1:0];
      end else begin
        tok_next.op       = u2c_pkg::TOK_LOOKUP;
        tok_next.code     = emit_cp;
        tok_next.byte_val = u2c_pkg::SPACE_CHAR;
      end
    end
  end

  // State and head token registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      pending    <= 2'd0;
      cls        <= u2c_pkg::CLS_NONE;
      any_output <= 1'b0;
      error_seen <= 1'b0;
      tok.vld    <= 1'b0;
    end else if (adv) begin
      partial    <= partial_next;
      pending    <= pending_next;
      cls        <= cls_next;
      any_output <= any_output_next;
      error_seen <= error_seen_next;
      tok        <= tok_next;
    end
  end

  // An open sequence always has a class, and an error closes any sequence.
  a_pending_has_class: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd0) |-> (cls != u2c_pkg::CLS_NONE))
    else $error("open sequence without minimum class");

  a_error_no_pending: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (pending == 2'd0))
    else $error("sequence still open after an error");

endmodule

// ===== design/u2c_cell.sv =====
// ----------------------------------------------------------------------------
// u2c_cell: one cell of the code table row
// Holds a group of table slots, takes loads addressed to it and matches
// lookups against its slots, then passes the token to the next cell.
// ----------------------------------------------------------------------------
module u2c_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [u2c_pkg::CELL_ID_W-1:0] cell_id,
  input  u2c_pkg::token_t               tok_in,
  output u2c_pkg::token_t               tok_out
);

  logic [u2c_pkg::CODE_W-1:0] entry [u2c_pkg::CELL_ENTRIES];
  u2c_pkg::token_t            tok_next;
  logic                       load_here;

  assign load_here = tok_in.vld && (tok_in.op == u2c_pkg::TOK_LOAD) &&
                     (tok_in.slot[u2c_pkg::SLOT_W-1:u2c_pkg::CELL_SEL_W] == cell_id);

  // Slot storage, written by loads that belong to this cell.
  always_ff @(posedge clk) begin
    if (adv && load_here) begin
      entry[tok_in.slot[u2c_pkg::CELL_SEL_W-1:0]] <= tok_in.code;
    end
  end

  // First matching slot of this cell; lower slots win.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && tok_in.op == u2c_pkg::TOK_LOOKUP && !tok_in.hit) begin
      for (int j = u2c_pkg::CELL_ENTRIES - 1; j >= 0; j--) begin
        if (entry[j] == tok_in.code &&
            {1'b0, cell_id, u2c_pkg::CELL_SEL_W'(j)} <
            (u2c_pkg::SLOT_W + 1)'(u2c_pkg::TABLE_ENTRIES)) begin
          tok_next.hit      = 1'b1;
          tok_next.byte_val = {1'b1, cell_id, u2c_pkg::CELL_SEL_W'(j)};
        end
      end
    end
  end

  // Hand the token to the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/u2c_result.sv =====
// ----------------------------------------------------------------------------
// u2c_result: result stage of the converter
// Keeps the lost counter, forms result words from tokens leaving the cell
// row and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module u2c_result (
  input  logic               clk,
  input  logic               rst,
  input  u2c_pkg::token_t    tok_in,
  input  logic               result_ready,
  output logic               result_valid,
  output u2c_pkg::out_word_t result,
  output logic               adv
);

  logic [u2c_pkg::CODE_W-1:0] lost, lost_next;
  logic                       is_lookup;
  logic                       is_summary;

  // The whole row moves when the output register is free or being emptied.
  assign adv        = !result_valid || result_ready;
  assign is_lookup  = tok_in.vld && (tok_in.op == u2c_pkg::TOK_LOOKUP);
  assign is_summary = tok_in.vld && (tok_in.op == u2c_pkg::TOK_DIRECT) &&
                      (tok_in.rkind == u2c_pkg::RES_SUMMARY);

  // Saturating count of characters replaced by a space.
  always_comb begin
    lost_next = lost;
    if (is_lookup && !tok_in.hit && lost < u2c_pkg::LOST_MAX) begin
      lost_next = lost + 21'd1;
    end
  end

  // Output register and lost counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      lost         <= '0;
    end else if (adv) begin
      lost <= is_summary ? '0 : lost_next;
      if (tok_in.vld && tok_in.op != u2c_pkg::TOK_LOAD) begin
        result_valid       <= 1'b1;
        result.result_kind <= tok_in.rkind;
        result.out_byte    <= tok_in.byte_val;
        result.lost_count  <= lost_next;
        result.failed      <= tok_in.failed;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  a_lost_bound: assert property (@(posedge clk) disable iff (rst)
    lost <= u2c_pkg::LOST_MAX)
    else $error("lost counter past its limit");

  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && is_summary) |=> (lost == '0))
    else $error("lost counter not cleared by summary");

endmodule

// ===== design/utf8_to_codepage_converter_core.sv =====
// Path: the decoder register takes an accepted word, then the row of 16 table cells of the
// 128-slot table and the output register each register it in turn. Throughput: one word
// per cycle; a stalled output holds the whole cell row. Reset clears the decode state, the
// lost counter and every token valid bit; the code table is not cleared and reads as
// undefined until loaded.
// ----------------------------------------------------------------------------
// utf8_to_codepage_converter_core: UTF-8 to 8-bit codepage converter
// Decodes and checks UTF-8 text and maps each code point to one byte by a
// systolic search through a row of table cells.
// ----------------------------------------------------------------------------
module utf8_to_codepage_converter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  u2c_pkg::in_word_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output u2c_pkg::out_word_t result
);

  logic            adv;
  u2c_pkg::token_t chain [u2c_pkg::NUM_CELLS + 1];

  assign item_ready = adv;

  // Decode front end feeds the head of the row.
  u2c_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .tok        (chain[0])
  );

  // Row of table cells.
  for (genvar i = 0; i < u2c_pkg::NUM_CELLS; i++) begin : g_cell
    u2c_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cell_id (u2c_pkg::CELL_ID_W'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Result stage at the tail of the row.
  u2c_result u_result (
    .clk          (clk),
    .rst          (rst),
    .tok_in       (chain[u2c_pkg::NUM_CELLS]),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .adv          (adv)
  );

endmodule
